@@ hdl/psh_pkg.sv @@
// Shared constants for the pair-sum histogram finder.
`default_nettype none

package psh_pkg;

   localparam int ValueBits          = 8;
   localparam int ValueRange         = 1 << ValueBits;
   localparam int TargetBits         = 9;
   localparam int MaxElementsDefault = 64;
   localparam int MaxResults         = 32;
   localparam int CsrAddrBits        = 3;
   localparam int CsrDataBits        = 32;

   localparam logic RegTargetSum = 1'b0;

endpackage

`default_nettype wire

@@ hdl/pair_sum_histogram_finder_core.sv @@
// Top level of the pair-sum finder: element store, count histogram and walk sequencer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | element_value, last_element
//   rsp     | out       | rsp_valid/stall    | first_value, second_value, pair_found,
//           |           |                    | last_result
//   csr     | in/out    | APB psel/penable   | target_sum at byte address 0
//
// A stored element is written to the store, then its histogram count is incremented; an
// element past capacity is dropped. The last element starts the walk over the stored
// elements on the single histogram read port, then a clear pass zeroes their entries.
// After reset all 256 histogram entries are zeroed while req_stall is held high.
// Output stalls hold the walk only when a result waits.
`default_nettype none

module pair_sum_histogram_finder_core #(
   parameter int MAX_ELEMENTS = psh_pkg::MaxElementsDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [psh_pkg::ValueBits-1:0]    req_element_value,
   input  wire logic                             req_last_element,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [psh_pkg::ValueBits-1:0]    rsp_first_value,
   output logic      [psh_pkg::ValueBits-1:0]    rsp_second_value,
   output logic                                  rsp_pair_found,
   output logic                                  rsp_last_result,

   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [psh_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  wire logic [psh_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic      [psh_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   localparam int IdxW   = $clog2(MAX_ELEMENTS);
   localparam int CntW   = $clog2(MAX_ELEMENTS + 1);
   localparam int VW     = psh_pkg::ValueBits;
   localparam int TW     = psh_pkg::TargetBits;
   localparam int TakenW = $clog2(psh_pkg::MaxResults + 1);
   localparam logic [TakenW-1:0] TakenMax = TakenW'(psh_pkg::MaxResults);
   localparam logic [CntW-1:0]   CntMax   = CntW'(MAX_ELEMENTS);

   typedef enum logic [11:0] {
      ST_INIT     = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_LOAD_INC = 12'b0000_0000_0100,
      ST_WALK_RD  = 12'b0000_0000_1000,
      ST_WALK_E   = 12'b0000_0001_0000,
      ST_WALK_CE  = 12'b0000_0010_0000,
      ST_WALK_CC  = 12'b0000_0100_0000,
      ST_DEC_C    = 12'b0000_1000_0000,
      ST_PAIR     = 12'b0001_0000_0000,
      ST_FINISH   = 12'b0010_0000_0000,
      ST_CLR_RD   = 12'b0100_0000_0000,
      ST_CLR_WR   = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    idx_ff, idx_in;
   logic [VW-1:0]      init_addr_ff, init_addr_in;
   logic [VW-1:0]      v_ff, v_in;
   logic               last_ff, last_in;
   logic [VW-1:0]      e_ff, e_in;
   logic [VW-1:0]      c_ff, c_in;
   logic [CntW-1:0]    ce_ff, ce_in;
   logic [CntW-1:0]    cc_ff, cc_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [VW-1:0]      pend_e_ff, pend_e_in;
   logic [VW-1:0]      pend_c_ff, pend_c_in;
   logic [TakenW-1:0]  taken_ff, taken_in;
   logic [TW-1:0]      target_ff, target_in;

   logic               out_valid_ff, out_valid_in;
   logic [VW-1:0]      out_first_ff, out_first_in;
   logic [VW-1:0]      out_second_ff, out_second_in;
   logic               out_found_ff, out_found_in;
   logic               out_last_ff, out_last_in;

   logic               store_wr_en;
   logic [VW-1:0]      store_rd_data;
   logic               hist_wr_en;
   logic [VW-1:0]      hist_wr_addr;
   logic [CntW-1:0]    hist_wr_data;
   logic [VW-1:0]      hist_rd_addr;
   logic [CntW-1:0]    hist_rd_data;

   logic               req_accept;
   logic               out_free;
   logic               out_load;
   logic               store_full;
   logic [CntW-1:0]    idx_next;
   logic               walk_done;
   logic [TW:0]        diff;
   logic               c_in_range;
   logic               csr_write;

   psh_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (count_ff[IdxW-1:0]),
      .wr_data (req_element_value),
      .rd_addr (idx_ff[IdxW-1:0]),
      .rd_data (store_rd_data)
   );

   psh_ram #(
      .WIDTH (CntW),
      .DEPTH (psh_pkg::ValueRange)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign store_full  = (count_ff == CntMax);
   assign store_wr_en = req_accept && !store_full;
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign idx_next    = idx_ff + CntW'(1);
   assign walk_done   = (idx_next == count_ff);
   assign diff        = {1'b0, target_ff} - {{(TW + 1 - VW){1'b0}}, e_ff};
   assign c_in_range  = (diff[TW:VW] == '0);

   assign csr_write   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == psh_pkg::RegTargetSum)
                        ? {{(psh_pkg::CsrDataBits - TW){1'b0}}, target_ff} : '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      init_addr_in  = init_addr_ff;
      v_in          = v_ff;
      last_in       = last_ff;
      e_in          = e_ff;
      c_in          = c_ff;
      ce_in         = ce_ff;
      cc_in         = cc_ff;
      pend_valid_in = pend_valid_ff;
      pend_e_in     = pend_e_ff;
      pend_c_in     = pend_c_ff;
      taken_in      = taken_ff;
      target_in     = target_ff;
      out_load      = 1'b0;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_found_in  = out_found_ff;
      out_last_in   = out_last_ff;
      hist_wr_en    = 1'b0;
      hist_wr_addr  = e_ff;
      hist_wr_data  = '0;
      hist_rd_addr  = e_ff;

      if (csr_write && (csr_paddr[2] == psh_pkg::RegTargetSum)) begin
         target_in = csr_pwdata[TW-1:0];
      end

      case (state_ff)
         ST_INIT: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = init_addr_ff;
            init_addr_in = init_addr_ff + VW'(1);
            if (init_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            hist_rd_addr = req_element_value;
            if (req_accept) begin
               v_in    = req_element_value;
               last_in = req_last_element;
               idx_in  = '0;
               if (!store_full) begin
                  count_in = count_ff + CntW'(1);
                  state_in = ST_LOAD_INC;
               end else if (req_last_element) begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_LOAD_INC: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = v_ff;
            hist_wr_data = hist_rd_data + CntW'(1);
            state_in     = last_ff ? ST_WALK_RD : ST_IDLE;
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_E;
         end
         ST_WALK_E: begin
            e_in         = store_rd_data;
            hist_rd_addr = store_rd_data;
            state_in     = ST_WALK_CE;
         end
         ST_WALK_CE: begin
            ce_in        = hist_rd_data;
            c_in         = diff[VW-1:0];
            hist_rd_addr = diff[VW-1:0];
            if ((hist_rd_data == '0) || !c_in_range) begin
               idx_in   = idx_next;
               state_in = walk_done ? ST_FINISH : ST_WALK_RD;
            end else begin
               state_in = ST_WALK_CC;
            end
         end
         ST_WALK_CC: begin
            cc_in = hist_rd_data;
            if ((hist_rd_data == '0) || ((e_ff == c_ff) && (ce_ff < CntW'(2)))) begin
               idx_in   = idx_next;
               state_in = walk_done ? ST_FINISH : ST_WALK_RD;
            end else begin
               hist_wr_en   = 1'b1;
               hist_wr_addr = e_ff;
               if (e_ff == c_ff) begin
                  hist_wr_data = ce_ff - CntW'(2);
                  state_in     = ST_PAIR;
               end else begin
                  hist_wr_data = ce_ff - CntW'(1);
                  state_in     = ST_DEC_C;
               end
            end
         end
         ST_DEC_C: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = c_ff;
            hist_wr_data = cc_ff - CntW'(1);
            state_in     = ST_PAIR;
         end
         ST_PAIR: begin
            if (taken_ff == TakenMax) begin
               idx_in   = idx_next;
               state_in = walk_done ? ST_FINISH : ST_WALK_RD;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_load      = 1'b1;
                  out_first_in  = pend_e_ff;
                  out_second_in = pend_c_ff;
                  out_found_in  = 1'b1;
                  out_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_e_in     = e_ff;
               pend_c_in     = c_ff;
               taken_in      = taken_ff + TakenW'(1);
               idx_in        = idx_next;
               state_in      = walk_done ? ST_FINISH : ST_WALK_RD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_first_in  = pend_valid_ff ? pend_e_ff : '0;
               out_second_in = pend_valid_ff ? pend_c_ff : '0;
               out_found_in  = pend_valid_ff;
               out_last_in   = 1'b1;
               idx_in        = '0;
               state_in      = ST_CLR_RD;
            end
         end
         ST_CLR_RD: begin
            state_in = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = store_rd_data;
            idx_in       = idx_next;
            if (walk_done) begin
               count_in      = '0;
               pend_valid_in = 1'b0;
               taken_in      = '0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_CLR_RD;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         count_ff      <= '0;
         idx_ff        <= '0;
         init_addr_ff  <= '0;
         pend_valid_ff <= 1'b0;
         taken_ff      <= '0;
         target_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         init_addr_ff  <= init_addr_in;
         pend_valid_ff <= pend_valid_in;
         taken_ff      <= taken_in;
         target_ff     <= target_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff          <= v_in;
      last_ff       <= last_in;
      e_ff          <= e_in;
      c_ff          <= c_in;
      ce_ff         <= ce_in;
      cc_ff         <= cc_in;
      pend_e_ff     <= pend_e_in;
      pend_c_ff     <= pend_c_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_found_ff  <= out_found_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_first_value  = out_first_ff;
   assign rsp_second_value = out_second_ff;
   assign rsp_pair_found   = out_found_ff;
   assign rsp_last_result  = out_last_ff;

endmodule

`default_nettype wire

@@ hdl/psh_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module psh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
